// File: sv/sha512_pkg.sv
// Package with types, constants and round functions of the SHA-512/384 core.
`default_nettype none
package sha512_pkg;

  typedef struct packed {
    logic [63:0] msg_word;
    logic [3:0]  byte_count;
    logic        final_word;
  } in_item_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [2:0]  word_index;
    logic        final_out;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } state_t;

  localparam logic [7:0] PadByte  = 8'h80;
  localparam int         Rounds   = 80;

  function automatic logic [63:0] k_const(input logic [6:0] i);
    logic [63:0] k;
    case (i)
      7'd0: k = 64'h428a2f98d728ae22; 7'd1: k = 64'h7137449123ef65cd;
      7'd2: k = 64'hb5c0fbcfec4d3b2f; 7'd3: k = 64'he9b5dba58189dbbc;
      7'd4: k = 64'h3956c25bf348b538; 7'd5: k = 64'h59f111f1b605d019;
      7'd6: k = 64'h923f82a4af194f9b; 7'd7: k = 64'hab1c5ed5da6d8118;
      7'd8: k = 64'hd807aa98a3030242; 7'd9: k = 64'h12835b0145706fbe;
      7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
      7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
      7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
      7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
      7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
      7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
      7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
      7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
      7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
      7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
      7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
      7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
      7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
      7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
      7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
      7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
      7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
      7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
      7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
      7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
      7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
      7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
      7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
      7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
      7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
      7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
      7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
      7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
      7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
      7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
      7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
      7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
      7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
      7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
      7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
      default: k = 64'h0;
    endcase
    return k;
  endfunction

  function automatic logic [63:0] init_hash(input logic mode, input logic [2:0] i);
    logic [63:0] v;
    case ({mode, i})
      4'd0: v = 64'h6a09e667f3bcc908; 4'd1: v = 64'hbb67ae8584caa73b;
      4'd2: v = 64'h3c6ef372fe94f82b; 4'd3: v = 64'ha54ff53a5f1d36f1;
      4'd4: v = 64'h510e527fade682d1; 4'd5: v = 64'h9b05688c2b3e6c1f;
      4'd6: v = 64'h1f83d9abfb41bd6b; 4'd7: v = 64'h5be0cd19137e2179;
      4'd8: v = 64'hcbbb9d5dc1059ed8; 4'd9: v = 64'h629a292a367cd507;
      4'd10: v = 64'h9159015a3070dd17; 4'd11: v = 64'h152fecd8f70e5939;
      4'd12: v = 64'h67332667ffc00b31; 4'd13: v = 64'h8eb44a8768581511;
      4'd14: v = 64'hdb0c2e0d64f98fa7; default: v = 64'h47b5481dbefa4fa4;
    endcase
    return v;
  endfunction

  function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
    return (x >> n) | (x << (64 - n));
  endfunction

endpackage
`default_nettype wire

// File: sv/sha512_hash_core.sv
// SHA-512/384 hash core with the message schedule held in a 16-entry memory.
//
//   channel  direction  handshake          payload
//   in       input      in_valid/in_stall  in_item_t (msg_word, byte_count, final_word)
//   out      output     out_valid/out_stall out_item_t (digest_word, word_index, final_out)
//   cfg      input      cfg_valid/cfg_ready hash_mode in bit 0
//
// A non-final word is stored; when it completes a block, the core prefetches the
// first schedule word, runs 80 rounds through the one-port-read schedule memory
// and makes one hash update. A final word pads a word per cycle, may run
// two compressions, then emits 6 or 8 digest words, one per cycle without stall.
// Reset is synchronous and reloads the SHA-512 initial hash; no clearing pass.
// Output stall holds the digest word; input stall is high whenever busy.
`default_nettype none
module sha512_hash_core
  import sha512_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data,
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire logic [63:0] cfg_data
);

  // Schedule memory: 16 words, written at one address, read at one, registered.
  logic [63:0] wmem [16];
  logic [63:0] wrd;
  logic        we;
  logic [3:0]  waddr, raddr;
  logic [63:0] wdata;

  always_ff @(posedge clk) begin
    if (we) wmem[waddr] <= wdata;
    wrd <= wmem[raddr];
  end

  logic [63:0] hw [8];
  logic [63:0] v [8];
  logic        mode;
  logic [3:0]  fill;
  logic [127:0] bits;
  state_t      state, state_next;
  logic [6:0]  rnd;
  logic [2:0]  oidx;
  logic        pad_final;      // pad run is for a final word
  logic        len_pending;    // pad byte word still to be written
  logic        len_block;      // current block carries the bit length
  logic [63:0] w_hist [16];    // window of recent schedule words for expansion

  logic in_acc;
  // A configuration write in idle takes priority over a request.
  assign in_stall = (state != ST_IDLE) || cfg_valid;
  assign in_acc   = in_valid && !in_stall;
  assign cfg_ready = (state == ST_IDLE);

  logic [3:0] n_eff;
  logic [63:0] mask, padded;
  always_comb begin
    n_eff = (in_data.byte_count > 4'd8) ? 4'd8 : in_data.byte_count;
    mask = (n_eff == 4'd0) ? 64'h0 : ~(64'h0) << (7'd64 - {n_eff[3:0], 3'b000});
    padded = (in_data.msg_word & mask)
           | ({56'h0, PadByte} << (7'd56 - {n_eff[3:0], 3'b000}));
  end

  // Expansion from window: w[t] = w[t-16] + s0(w[t-15]) + w[t-7] + s1(w[t-2]).
  logic [63:0] s0, s1, wexp, wcur, t1, t2, sig0, sig1, chs, mj;
  always_comb begin
    s0 = rotr(w_hist[1], 1) ^ rotr(w_hist[1], 8) ^ (w_hist[1] >> 7);
    s1 = rotr(w_hist[14], 19) ^ rotr(w_hist[14], 61) ^ (w_hist[14] >> 6);
    wexp = w_hist[0] + s0 + w_hist[9] + s1;
    wcur = (rnd < 7'd16) ? wrd : wexp;
    sig1 = rotr(v[4], 14) ^ rotr(v[4], 18) ^ rotr(v[4], 41);
    chs = (v[4] & v[5]) ^ (~v[4] & v[6]);
    t1 = v[7] + sig1 + chs + k_const(rnd) + wcur;
    sig0 = rotr(v[0], 28) ^ rotr(v[0], 34) ^ rotr(v[0], 39);
    mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t2 = sig0 + mj;
  end

  logic [2:0] last_idx;
  assign last_idx = mode ? 3'd5 : 3'd7;

  always_comb begin
    state_next = state;
    we = 1'b0;
    waddr = fill;
    wdata = 64'h0;
    raddr = 4'd0;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          we = 1'b1;
          if (!in_data.final_word) begin
            wdata = in_data.msg_word;
            if (fill == 4'd15) state_next = ST_LOAD;
          end else if (n_eff == 4'd8) begin
            wdata = in_data.msg_word;
            state_next = (fill == 4'd15) ? ST_LOAD : ST_PAD;
          end else begin
            wdata = padded;
            state_next = (fill == 4'd15) ? ST_LOAD : ST_PAD;
          end
        end
      end
      ST_PAD: begin
        we = 1'b1;
        if (len_pending) wdata = {56'h0, PadByte} << 56;
        else if (len_block && fill == 4'd14) wdata = bits[127:64];
        else if (len_block && fill == 4'd15) wdata = bits[63:0];
        if (fill == 4'd15) state_next = ST_LOAD;
      end
      ST_LOAD: begin
        raddr = 4'd0;
        state_next = ST_ROUND;
      end
      ST_ROUND: begin
        raddr = rnd[3:0] + 4'd1;
        if (rnd == 7'(Rounds - 1)) state_next = ST_ADD;
      end
      ST_ADD: begin
        if (!pad_final) state_next = ST_IDLE;
        else if (len_block) state_next = ST_EMIT;
        else state_next = ST_PAD;
      end
      ST_EMIT: begin
        if (!out_stall && oidx == last_idx) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      mode <= 1'b0;
      fill <= 4'd0;
      bits <= '0;
      pad_final <= 1'b0;
      len_pending <= 1'b0;
      len_block <= 1'b0;
      rnd <= 7'd0;
      oidx <= 3'd0;
      for (int i = 0; i < 8; i++) hw[i] <= init_hash(1'b0, 3'(i));
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          if (cfg_valid) begin
            mode <= cfg_data[0];
            fill <= 4'd0;
            bits <= '0;
            for (int i = 0; i < 8; i++) hw[i] <= init_hash(cfg_data[0], 3'(i));
          end else if (in_acc) begin
            fill <= fill + 4'd1;
            if (!in_data.final_word) begin
              bits <= bits + 128'd64;
              pad_final <= 1'b0;
              len_block <= 1'b0;
            end else begin
              bits <= bits + {121'd0, n_eff, 3'b000};
              pad_final <= 1'b1;
              len_pending <= (n_eff == 4'd8);
              // The length fits behind the pad byte only up to word 13.
              len_block <= (n_eff != 4'd8) && (fill <= 4'd13);
            end
          end
        end
        ST_PAD: begin
          fill <= fill + 4'd1;
          len_pending <= 1'b0;
          if (len_pending) len_block <= (fill <= 4'd13);
        end
        ST_LOAD: begin
          rnd <= 7'd0;
          for (int i = 0; i < 8; i++) v[i] <= hw[i];
        end
        ST_ROUND: begin
          rnd <= rnd + 7'd1;
          for (int i = 0; i < 15; i++) w_hist[i] <= w_hist[i + 1];
          w_hist[15] <= wcur;
          v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
          v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
        end
        ST_ADD: begin
          for (int i = 0; i < 8; i++) hw[i] <= hw[i] + v[i];
          oidx <= 3'd0;
          // A padded block without the length is followed by the length block.
          if (pad_final && !len_block) len_block <= 1'b1;
        end
        ST_EMIT: begin
          if (!out_stall) begin
            oidx <= oidx + 3'd1;
            if (oidx == last_idx) begin
              fill <= 4'd0;
              bits <= '0;
              pad_final <= 1'b0;
              for (int i = 0; i < 8; i++) hw[i] <= init_hash(mode, 3'(i));
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid = (state == ST_EMIT);
  assign out_data.digest_word = hw[oidx];
  assign out_data.word_index  = oidx;
  assign out_data.final_out   = (oidx == last_idx);

`ifndef SYNTHESIS
  a_no_in_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> in_stall) else $error("input taken while busy");
  a_emit_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(oidx))) else $error("digest dropped");
  a_round_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND) |-> (rnd < 7'(Rounds))) else $error("round counter overrun");
  a_fill_reset: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && out_data.final_out) |=> (fill == 4'd0))
    else $error("fill not cleared after digest");
`endif

endmodule
`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench for the SHA-512/384 hash core with random flow control.
`timescale 1ns / 1ps
module testbench;
  import sha512_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [63:0] cfg_data = '0;

  sha512_hash_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  localparam logic [63:0] ROUND_K [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };
  localparam logic [63:0] IV_512 [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };
  localparam logic [63:0] IV_384 [8] = '{
    64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17, 64'h152fecd8f70e5939,
    64'h67332667ffc00b31, 64'h8eb44a8768581511, 64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4
  };

  // Predictor state.
  logic        mode_sel;
  logic [63:0] chain [8];
  logic [63:0] blk [16];
  logic [7:0]  fill;
  logic [127:0] bit_len;

  out_item_t digest_q[$];
  in_item_t  request_q[$];
  int        errors = 0;
  longint    cycles = 0;
  bit        hold_sender = 1'b0;
  bit        all_queued = 1'b0;
  bit        in_taken = 1'b0;
  int        in_gap = 0;
  int        out_gap = 0;

  function automatic logic [63:0] ror(logic [63:0] x, int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  task automatic compress_block();
    logic [63:0] w [80];
    logic [63:0] v [8];
    logic [63:0] t1, t2;
    for (int i = 0; i < 16; i++) w[i] = blk[i];
    for (int i = 16; i < 80; i++)
      w[i] = w[i-16] + (ror(w[i-15], 1) ^ ror(w[i-15], 8) ^ (w[i-15] >> 7)) + w[i-7]
             + (ror(w[i-2], 19) ^ ror(w[i-2], 61) ^ (w[i-2] >> 6));
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int i = 0; i < 80; i++) begin
      t1 = v[7] + (ror(v[4], 14) ^ ror(v[4], 18) ^ ror(v[4], 41))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
      t2 = (ror(v[0], 28) ^ ror(v[0], 34) ^ ror(v[0], 39))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] += v[i];
  endtask

  task automatic push_block_word(logic [63:0] w);
    blk[fill[6:3]] = w;
    fill = fill + 8'd8;
    if (fill >= 8'd128) begin
      compress_block();
      fill = 8'd0;
    end
  endtask

  task automatic reload_chain();
    for (int i = 0; i < 8; i++) chain[i] = mode_sel ? IV_384[i] : IV_512[i];
    fill = 8'd0;
    bit_len = '0;
  endtask

  task automatic hash_word(in_item_t it);
    int n;
    int cnt;
    logic [63:0] mask;
    out_item_t r;
    if (!it.final_word) begin
      bit_len += 128'd64;
      push_block_word(it.msg_word);
      return;
    end
    n = (it.byte_count > 8) ? 8 : int'(it.byte_count);
    bit_len += 128'(n * 8);
    if (n == 8) begin
      push_block_word(it.msg_word);
      push_block_word({PadByte, 56'h0});
    end else begin
      mask = (n == 0) ? 64'h0 : ~64'h0 << (64 - 8 * n);
      push_block_word((it.msg_word & mask) | (64'(PadByte) << (56 - 8 * n)));
    end
    while (fill != 8'd112) push_block_word(64'h0);
    push_block_word(bit_len[127:64]);
    push_block_word(bit_len[63:0]);
    cnt = mode_sel ? 6 : 8;
    for (int i = 0; i < cnt; i++) begin
      r.digest_word = chain[i];
      r.word_index = 3'(i);
      r.final_out = (i == cnt - 1);
      digest_q.push_back(r);
    end
    reload_chain();
  endtask

  initial begin
    forever #6 clk = ~clk;
  end

  // Request and output-stall driver.
  always @(negedge clk) begin
    if (!rst) begin
      if (in_taken) begin
        // Accepted at the last rising edge.
        hash_word(in_data);
        void'(request_q.pop_front());
        in_gap = $urandom_range(0, 15);
        if ($urandom_range(0, 3) == 0) in_gap = 0;
      end
      if (in_valid && !in_taken) begin
        // A stalled request stays on the bus unchanged.
        in_valid <= 1'b1;
      end else if (request_q.size() > 0 && in_gap == 0 && !hold_sender) begin
        in_valid <= 1'b1;
        in_data <= request_q[0];
      end else begin
        in_valid <= 1'b0;
        if (in_gap > 0) in_gap--;
      end
      if (out_gap > 0) begin
        out_stall <= 1'b1;
        out_gap--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Digest monitor.
  always @(posedge clk) begin
    out_item_t exp_item;
    cycles++;
    in_taken = !rst && in_valid && !in_stall;
    if (!rst && out_valid && !out_stall) begin
      if (digest_q.size() == 0) begin
        $display("%0t: unexpected digest word, actual %h", $time, out_data);
        errors++;
      end else begin
        exp_item = digest_q.pop_front();
        if (out_data.digest_word !== exp_item.digest_word) begin
          $display("%0t: digest_word expected %h actual %h", $time,
                   exp_item.digest_word, out_data.digest_word);
          errors++;
        end
        if (out_data.word_index !== exp_item.word_index) begin
          $display("%0t: word_index expected %0d actual %0d", $time,
                   exp_item.word_index, out_data.word_index);
          errors++;
        end
        if (out_data.final_out !== exp_item.final_out) begin
          $display("%0t: final_out expected %0d actual %0d", $time,
                   exp_item.final_out, out_data.final_out);
          errors++;
        end
      end
      if ($urandom_range(0, 2) == 0) out_gap = $urandom_range(0, 15);
    end
    if (cycles > 64'd2000000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic add_req(logic [63:0] w, logic [3:0] bc, logic fin);
    in_item_t it;
    it.msg_word = w;
    it.byte_count = bc;
    it.final_word = fin;
    request_q.push_back(it);
  endtask

  task automatic wait_drained();
    while (request_q.size() > 0 || digest_q.size() > 0) @(posedge clk);
    // A trailing non-final word may still be compressing.
    repeat (200) @(posedge clk);
  endtask

  task automatic write_mode(logic [63:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    mode_sel = v[0];
    reload_chain();
  endtask

  task automatic random_message(int words);
    for (int i = 0; i < words - 1; i++)
      add_req({$urandom, $urandom}, 4'($urandom_range(0, 15)), 1'b0);
    add_req({$urandom, $urandom}, 4'($urandom_range(0, 15)), 1'b1);
  endtask

  initial begin
    int total;
    mode_sel = 1'b0;
    for (int i = 0; i < 16; i++) blk[i] = '0;
    reload_chain();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty message, every byte count, max values, block boundaries.
    add_req(64'hffff_ffff_ffff_ffff, 4'd0, 1'b1);
    for (int n = 1; n <= 15; n++) add_req(64'hffff_ffff_ffff_ffff, 4'(n), 1'b1);
    for (int i = 0; i < 14; i++) add_req(64'h0, 4'd15, 1'b0);
    add_req(64'h0123_4567_89ab_cdef, 4'd8, 1'b1);
    for (int i = 0; i < 15; i++) add_req(64'hffff_ffff_ffff_ffff, 4'd0, 1'b0);
    add_req(64'ha5a5_5a5a_0000_ffff, 4'd4, 1'b1);
    wait_drained();

    write_mode(64'hffff_ffff_ffff_ffff);
    add_req(64'h0, 4'd0, 1'b1);
    add_req(64'h6162_6300_0000_0000, 4'd3, 1'b1);
    // Partial message abandoned by the mode write.
    add_req(64'h1234, 4'd8, 1'b0);
    wait_drained();
    write_mode(64'h2);

    total = 0;
    while (total < 450) begin
      int len;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 6);
      random_message(len);
      total += len;
      if ($urandom_range(0, 19) == 0) begin
        hold_sender = 1'b1;
        while (digest_q.size() > 0 || in_valid) @(posedge clk);
        hold_sender = 1'b0;
      end
      if ($urandom_range(0, 24) == 0) begin
        wait_drained();
        write_mode({$urandom, $urandom});
      end
      while (request_q.size() > 40) @(posedge clk);
    end
    wait_drained();
    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
